// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

	localparam int ALPHABET_MAX = 64;
	localparam int COEFF_COUNT  = 4;
	localparam int SYM_W        = 6;
	localparam int MOD_W        = 7;
	localparam int PER_W        = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 8;
	// reduction lanes: restart differences, stored differences, phase residue
	localparam int LANES        = 2 * COEFF_COUNT + 1;
	localparam int LANE_W       = 9;
	localparam int STEP_W       = 4;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ALPHABET_SIZE,
		REG_KEY_MODE,
		REG_DIRECTION,
		REG_PERIOD_LENGTH,
		REG_COEF_ZERO,
		REG_COEF_ONE,
		REG_COEF_TWO,
		REG_COEF_THREE
	} cfg_reg_t;

	typedef struct packed {
		logic [SYM_W-1:0] symbol_index;
		logic             restart;
	} sym_item_t;

	typedef struct packed {
		logic [SYM_W-1:0] out_index;
		logic             not_in_alphabet;
	} res_item_t;

	typedef struct packed {
		logic [MOD_W-1:0]                  alphabet_size;
		logic                              key_mode;
		logic                              direction;
		logic [PER_W-1:0]                  period_length;
		logic [COEFF_COUNT-1:0][SYM_W-1:0] coef;
	} cfg_t;

	typedef struct packed {
		logic [COEFF_COUNT-1:0][SYM_W-1:0] diff;
		logic [PER_W-1:0]                  phase;
	} core_state_t;

	typedef struct packed {
		logic [COEFF_COUNT-1:0][SYM_W-1:0] load_d;
		logic [COEFF_COUNT-1:0][SYM_W-1:0] red_d;
		logic [SYM_W-1:0]                  red_r;
		logic                              done;
		logic                              busy;
	} prep_out_t;

	function automatic logic [MOD_W-1:0] eff_modulus(input logic [MOD_W-1:0] a);
		logic [MOD_W-1:0] m;
		m = a;
		if (a < MOD_W'(2))
			m = MOD_W'(2);
		else if (a > MOD_W'(ALPHABET_MAX))
			m = MOD_W'(ALPHABET_MAX);
		return m;
	endfunction

	function automatic logic [PER_W-1:0] eff_period(input logic [PER_W-1:0] p);
		return (p == '0) ? PER_W'(1) : p;
	endfunction

endpackage

// ===== rtl/tsc_prep.sv =====
module tsc_prep (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsc_pkg::cfg_t        cfg,
	input  logic                 start,
	input  tsc_pkg::core_state_t state,
	output tsc_pkg::prep_out_t   st
);
	import tsc_pkg::*;

	logic [LANE_W-1:0]       x_q [LANES];
	logic [LANE_W-1:0]       x_init [LANES];
	logic [LANE_W-1:0]       x_next [LANES];
	logic [PER_W-1:0]        div [LANES];
	logic [LANE_W+PER_W-1:0] sub [LANES];
	logic [STEP_W-1:0]       step_q;
	logic                    round_q;
	logic                    run_q;
	logic                    start_q;
	logic                    done_q;
	logic [MOD_W-1:0]        m;
	logic [PER_W-1:0]        per;

	assign m   = eff_modulus(cfg.alphabet_size);
	assign per = eff_period(cfg.period_length);

	// forward differences of the key polynomial at position zero
	always_comb begin
		x_init[0] = LANE_W'(cfg.coef[0]);
		x_init[1] = LANE_W'(cfg.coef[1]) + LANE_W'(cfg.coef[2]) + LANE_W'(cfg.coef[3]);
		x_init[3] = LANE_W'({cfg.coef[3], 2'b00}) + LANE_W'({cfg.coef[3], 1'b0});
		x_init[2] = LANE_W'({cfg.coef[2], 1'b0}) + x_init[3];
		for (int k = 0; k < COEFF_COUNT; k++)
			x_init[COEFF_COUNT + k] = LANE_W'(state.diff[k]);
		x_init[LANES-1] = LANE_W'(state.phase);
	end

	// restoring reduction, one shifted compare and subtract per cycle
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			div[i] = (i == LANES - 1 && !round_q) ? per : PER_W'(m);
			sub[i] = (LANE_W+PER_W)'(div[i]) << step_q;
			if ((LANE_W+PER_W)'(x_q[i]) >= sub[i])
				x_next[i] = x_q[i] - sub[i][LANE_W-1:0];
			else
				x_next[i] = x_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
			run_q   <= 1'b0;
			round_q <= 1'b0;
			step_q  <= '0;
			done_q  <= 1'b0;
			for (int i = 0; i < LANES; i++)
				x_q[i] <= '0;
		end else begin
			start_q <= start;
			done_q  <= 1'b0;
			if (start_q) begin
				x_q     <= x_init;
				run_q   <= 1'b1;
				round_q <= 1'b0;
				step_q  <= STEP_W'(LANE_W - 1);
			end else if (run_q) begin
				x_q <= x_next;
				if (step_q == '0) begin
					if (round_q) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end else begin
						// second round takes the phase residue modulo the alphabet
						round_q <= 1'b1;
						step_q  <= STEP_W'(LANE_W - 1);
					end
				end else begin
					step_q <= step_q - STEP_W'(1);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < COEFF_COUNT; k++) begin
			st.load_d[k] = x_q[k][SYM_W-1:0];
			st.red_d[k]  = x_q[COEFF_COUNT + k][SYM_W-1:0];
		end
		st.red_r = x_q[LANES-1][SYM_W-1:0];
		st.done  = done_q;
		st.busy  = start | start_q | run_q | done_q;
	end

endmodule

// ===== rtl/tsc_core.sv =====
module tsc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tsc_pkg::cfg_t        cfg,
	input  tsc_pkg::prep_out_t   prep,
	input  logic                 sym_valid,
	output logic                 sym_ready,
	input  tsc_pkg::sym_item_t   sym_data,
	output logic                 res_valid,
	input  logic                 res_ready,
	output tsc_pkg::res_item_t   res_data,
	output tsc_pkg::core_state_t state
);
	import tsc_pkg::*;

	logic                              v_s1;
	sym_item_t                         item_s1;
	logic                              v_s2;
	res_item_t                         res_s2;
	// raw differences as last written; dred_q is the same set reduced by the current modulus
	logic [COEFF_COUNT-1:0][SYM_W-1:0] diff_q;
	logic [COEFF_COUNT-1:0][SYM_W-1:0] dred_q;
	logic [PER_W-1:0]                  phase_q;
	logic [SYM_W-1:0]                  resid_q;

	logic                              adv;
	logic [MOD_W-1:0]                  m;
	logic [PER_W-1:0]                  per;
	logic [COEFF_COUNT-1:0][SYM_W-1:0] d_use;
	logic [COEFF_COUNT-1:0][SYM_W-1:0] d_n;
	logic [COEFF_COUNT-1:0][SYM_W-1:0] raw_n;
	logic [PER_W-1:0]                  phase_use;
	logic [SYM_W-1:0]                  r_use;
	logic [SYM_W-1:0]                  shift;
	logic                              flag;
	logic [PER_W-1:0]                  sum;
	logic [PER_W-1:0]                  res;
	logic [MOD_W-1:0]                  dsum;
	logic [PER_W:0]                    phase_inc;
	logic                              wrap;
	logic [MOD_W-1:0]                  r_inc;
	logic [SYM_W-1:0]                  r_n;
	logic [PER_W-1:0]                  phase_n;

	assign m   = eff_modulus(cfg.alphabet_size);
	assign per = eff_period(cfg.period_length);

	assign adv       = v_s1 && (!v_s2 || res_ready) && !prep.busy;
	assign sym_ready = !v_s1 || adv;

	always_comb begin
		d_use     = item_s1.restart ? prep.load_d : dred_q;
		phase_use = item_s1.restart ? '0 : phase_q;
		r_use     = item_s1.restart ? '0 : resid_q;
		// stored shift terms are always below the modulus
		shift     = cfg.key_mode ? r_use : d_use[0];
		flag      = MOD_W'(item_s1.symbol_index) >= m;

		if (cfg.direction)
			sum = PER_W'(item_s1.symbol_index) + PER_W'(m) - PER_W'(shift);
		else
			sum = PER_W'(item_s1.symbol_index) + PER_W'(shift);
		res = (sum >= PER_W'(m)) ? sum - PER_W'(m) : sum;

		for (int k = 0; k < COEFF_COUNT - 1; k++) begin
			dsum = MOD_W'(d_use[k]) + MOD_W'(d_use[k+1]);
			if (dsum >= m)
				dsum = dsum - m;
			d_n[k] = dsum[SYM_W-1:0];
		end
		dsum = '0;
		d_n[COEFF_COUNT-1] = d_use[COEFF_COUNT-1];

		// top difference never steps, so its raw value only changes on restart
		raw_n = d_n;
		raw_n[COEFF_COUNT-1] = item_s1.restart ? prep.load_d[COEFF_COUNT-1] :
			diff_q[COEFF_COUNT-1];

		phase_inc = (PER_W+1)'(phase_use) + (PER_W+1)'(1);
		wrap      = phase_inc >= (PER_W+1)'(per);
		phase_n   = wrap ? '0 : phase_inc[PER_W-1:0];
		r_inc     = MOD_W'(r_use) + MOD_W'(1);
		if (wrap || r_inc == m)
			r_n = '0;
		else
			r_n = r_inc[SYM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			diff_q  <= '0;
			dred_q  <= '0;
			phase_q <= '0;
			resid_q <= '0;
		end else begin
			if (sym_valid && sym_ready)
				v_s1 <= 1'b1;
			else if (adv)
				v_s1 <= 1'b0;

			if (adv)
				v_s2 <= 1'b1;
			else if (res_ready)
				v_s2 <= 1'b0;

			if (adv) begin
				diff_q  <= raw_n;
				dred_q  <= d_n;
				phase_q <= phase_n;
				resid_q <= r_n;
			end else if (prep.done) begin
				dred_q  <= prep.red_d;
				resid_q <= prep.red_r;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sym_valid && sym_ready)
			item_s1 <= sym_data;
		if (adv) begin
			res_s2.out_index       <= flag ? item_s1.symbol_index : res[SYM_W-1:0];
			res_s2.not_in_alphabet <= flag;
		end
	end

	assign res_valid   = v_s2;
	assign res_data    = res_s2;
	assign state.diff  = diff_q;
	assign state.phase = phase_q;

endmodule

// ===== rtl/trithemius_shift_cipher_unit.sv =====
// channel   | signals                          | moves
// sym       | sym_valid, sym_ready, sym_data   | one symbol request in
// res       | res_valid, res_ready, res_data   | one shifted symbol out
// cfg       | cfg_we, cfg_index, cfg_wdata     | register write, no wait
//
// One request a cycle unless the output or key reduction stalls; each result is registered.
// Reset: registers at defaults, position zero, all key differences zero.
// After a register write the reduction sequencer re-derives the key state in two
// nine-step restoring rounds; one request waits in the input stage meanwhile.
// A stalled result holds the output register while the input stage takes one more request.
module trithemius_shift_cipher_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sym_valid,
	output logic                              sym_ready,
	input  tsc_pkg::sym_item_t                sym_data,
	output logic                              res_valid,
	input  logic                              res_ready,
	output tsc_pkg::res_item_t                res_data,
	input  logic                              cfg_we,
	input  logic [tsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tsc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import tsc_pkg::*;

	cfg_t        cfg_q;
	prep_out_t   prep_st;
	core_state_t core_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alphabet_size <= MOD_W'(26);
			cfg_q.key_mode      <= 1'b0;
			cfg_q.direction     <= 1'b0;
			cfg_q.period_length <= PER_W'(1);
			cfg_q.coef          <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_ALPHABET_SIZE: cfg_q.alphabet_size <= cfg_wdata[MOD_W-1:0];
				REG_KEY_MODE:      cfg_q.key_mode      <= cfg_wdata[0];
				REG_DIRECTION:     cfg_q.direction     <= cfg_wdata[0];
				REG_PERIOD_LENGTH: cfg_q.period_length <= cfg_wdata[PER_W-1:0];
				REG_COEF_ZERO:     cfg_q.coef[0]       <= cfg_wdata[SYM_W-1:0];
				REG_COEF_ONE:      cfg_q.coef[1]       <= cfg_wdata[SYM_W-1:0];
				REG_COEF_TWO:      cfg_q.coef[2]       <= cfg_wdata[SYM_W-1:0];
				REG_COEF_THREE:    cfg_q.coef[3]       <= cfg_wdata[SYM_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	tsc_prep u_prep (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (cfg_we),
		.state  (core_st),
		.st     (prep_st)
	);

	tsc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.prep      (prep_st),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym_data  (sym_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.state     (core_st)
	);

	a_write_starts_prep: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> prep_st.busy)
		else $error("register write did not start key reduction");

	a_no_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		prep_st.busy && !res_valid |=> !res_valid)
		else $error("result produced during key reduction");

	a_phase_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		core_st.phase != PER_W'(255))
		else $error("message phase beyond largest period");

endmodule
